@@ hdl/sbg_pkg.sv @@
package sbg_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_HP_GAIN   = 3'd0;
    localparam logic [2:0] CFG_HP_FB1    = 3'd1;
    localparam logic [2:0] CFG_HP_FB2    = 3'd2;
    localparam logic [2:0] CFG_LP_GAIN   = 3'd3;
    localparam logic [2:0] CFG_LP_FB1    = 3'd4;
    localparam logic [2:0] CFG_LP_FB2    = 3'd5;
    localparam logic [2:0] CFG_GATE_THR  = 3'd6;

    // Reset values of the coefficient and threshold registers.
    localparam logic        [30:0] HP_GAIN_RST = 31'd1044336330;
    localparam logic signed [31:0] HP_FB1_RST  = -32'sd2087868428;
    localparam logic signed [31:0] HP_FB2_RST  = 32'sd1015738291;
    localparam logic        [30:0] LP_GAIN_RST = 31'd40093520;
    localparam logic signed [31:0] LP_FB1_RST  = -32'sd1485939499;
    localparam logic signed [31:0] LP_FB2_RST  = 32'sd572572828;
    localparam logic        [14:0] GATE_THR_RST = 15'd20;

    // Saturation limits of the stored section output and of a sample.
    localparam logic [39:0] Y_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] Y_MIN = 40'h80_0000_0000;
    localparam logic [15:0] S_MAX = 16'h7FFF;
    localparam logic [15:0] S_MIN = 16'h8000;

    // Sections are worked in the order left high-pass, left low-pass,
    // right high-pass, right low-pass; bit 1 is the channel, bit 0 the section.
    localparam logic [1:0] JOB_FIRST = 2'd0;
    localparam logic [1:0] JOB_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PART,
        ST_SUM,
        ST_RES,
        ST_DELIVER
    } sbg_state_t;

    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic       part;
        logic       acc;
        logic       res;
        logic       load_out;
        logic [1:0] job;
    } sbg_cmd_t;

endpackage

@@ hdl/sbg_ctrl.sv @@
module sbg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output sbg_pkg::sbg_cmd_t cmd
);
    import sbg_pkg::*;

    sbg_state_t state_reg, state_next;
    logic [1:0] job_reg, job_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output register may be loaded when empty or being emptied.
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    // State, section counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            job_reg     <= JOB_FIRST;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        cmd          = '0;
        cmd.job      = job_reg;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                job_next    = JOB_FIRST;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PART;
            end
            ST_PART:
            begin
                cmd.part   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                cmd.res = 1'b1;
                if (job_reg == JOB_LAST)
                begin
                    job_next   = JOB_FIRST;
                    state_next = ST_DELIVER;
                end
                else
                begin
                    job_next   = job_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A new word always starts at the left high-pass section.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL && job_reg == JOB_FIRST))
        else $error("accepted word did not start the first section");

    // The counter is back at the first section whenever a word may enter.
    a_idle_job: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (job_reg == JOB_FIRST))
        else $error("section counter not cleared in idle");

    // After the last section the result goes to the output stage.
    a_last_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES && job_reg == JOB_LAST) |=> (state_reg == ST_DELIVER))
        else $error("last section did not lead to delivery");

    // Loading the output register raises valid and frees the input side.
    a_deliver_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (m_valid_reg && s_tready))
        else $error("delivery did not present the result and return to idle");

endmodule

@@ hdl/sbg_datapath.sv @@
module sbg_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sbg_pkg::sbg_cmd_t cmd,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [31:0]       s_tdata,
    output logic [31:0]       m_tdata
);
    import sbg_pkg::*;

    // Configuration registers.
    logic        [30:0] hp_gain_reg, lp_gain_reg;
    logic signed [31:0] hp_fb1_reg, hp_fb2_reg, lp_fb1_reg, lp_fb2_reg;
    logic        [14:0] gate_thr_reg;

    // Section history: entry j belongs to section j of the working order.
    logic signed [15:0] x1_reg [4];
    logic signed [15:0] x2_reg [4];
    logic signed [39:0] y1_reg [4];
    logic signed [39:0] y2_reg [4];

    // Word and intermediate registers.
    logic signed [15:0] in_left_reg, in_right_reg;
    logic signed [15:0] sec_result_reg, res_left_reg, res_right_reg;
    logic        [31:0] m_data_reg;
    logic signed [50:0] ff_reg;
    logic signed [55:0] ph1_reg, ph2_reg;
    logic signed [48:0] pl1_reg, pl2_reg;
    logic signed [36:0] ffq_reg;
    logic signed [42:0] p1_reg, p2_reg;
    logic signed [39:0] y_reg;

    logic               ch, sec;
    logic signed [15:0] x0, x1, x2;
    logic signed [39:0] y1, y2;
    logic        [30:0] gain_sel;
    logic signed [31:0] fb1_sel, fb2_sel;
    logic signed [18:0] x0e, x2e, x1d, tap_sum;
    logic signed [50:0] ff_mul;
    logic signed [55:0] ph1_mul, ph2_mul;
    logic signed [48:0] pl1_mul, pl2_mul;
    logic        [56:0] t1, t2;
    logic        [44:0] acc;
    logic        [39:0] y_sat;
    logic        [40:0] rnd;
    logic        [24:0] q;
    logic signed [15:0] r;
    logic signed [16:0] r17, thr17;
    logic signed [15:0] g;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_gain_reg  <= HP_GAIN_RST;
            hp_fb1_reg   <= HP_FB1_RST;
            hp_fb2_reg   <= HP_FB2_RST;
            lp_gain_reg  <= LP_GAIN_RST;
            lp_fb1_reg   <= LP_FB1_RST;
            lp_fb2_reg   <= LP_FB2_RST;
            gate_thr_reg <= GATE_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HP_GAIN:  hp_gain_reg  <= cfg_data[30:0];
                CFG_HP_FB1:   hp_fb1_reg   <= cfg_data;
                CFG_HP_FB2:   hp_fb2_reg   <= cfg_data;
                CFG_LP_GAIN:  lp_gain_reg  <= cfg_data[30:0];
                CFG_LP_FB1:   lp_fb1_reg   <= cfg_data;
                CFG_LP_FB2:   lp_fb2_reg   <= cfg_data;
                CFG_GATE_THR: gate_thr_reg <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    // Operand selection for the section in hand.
    assign ch       = cmd.job[1];
    assign sec      = cmd.job[0];
    assign x0       = sec ? sec_result_reg : (ch ? in_right_reg : in_left_reg);
    assign x1       = x1_reg[cmd.job];
    assign x2       = x2_reg[cmd.job];
    assign y1       = y1_reg[cmd.job];
    assign y2       = y2_reg[cmd.job];
    assign gain_sel = sec ? lp_gain_reg : hp_gain_reg;
    assign fb1_sel  = sec ? lp_fb1_reg : hp_fb1_reg;
    assign fb2_sel  = sec ? lp_fb2_reg : hp_fb2_reg;

    // Numerator taps: 1,-2,1 for high-pass and 1,2,1 for low-pass.
    assign x0e     = {{3{x0[15]}}, x0};
    assign x2e     = {{3{x2[15]}}, x2};
    assign x1d     = {{2{x1[15]}}, x1, 1'b0};
    assign tap_sum = sec ? (x0e + x1d + x2e) : (x0e - x1d + x2e);

    // Products: the feedback terms are split at bit 16 of the stored output.
    assign ff_mul  = $signed({1'b0, gain_sel}) * tap_sum;
    assign ph1_mul = fb1_sel * $signed(y1[39:16]);
    assign pl1_mul = fb1_sel * $signed({1'b0, y1[15:0]});
    assign ph2_mul = fb2_sel * $signed(y2[39:16]);
    assign pl2_mul = fb2_sel * $signed({1'b0, y2[15:0]});

    // Recombine the partial products and floor each term to 16 fraction bits.
    assign t1 = {ph1_reg[55], ph1_reg} + {{24{pl1_reg[48]}}, pl1_reg[48:16]};
    assign t2 = {ph2_reg[55], ph2_reg} + {{24{pl2_reg[48]}}, pl2_reg[48:16]};

    // Sum the three terms and saturate to the 40-bit stored width.
    assign acc = {{8{ffq_reg[36]}}, ffq_reg} - {{2{p1_reg[42]}}, p1_reg}
               - {{2{p2_reg[42]}}, p2_reg};
    always_comb
    begin
        if ((acc[44:39] == 6'b000000) || (acc[44:39] == 6'b111111))
        begin
            y_sat = acc[39:0];
        end
        else
        begin
            y_sat = acc[44] ? Y_MIN : Y_MAX;
        end
    end

    // Truncate toward zero to an integer, then saturate to 16 bits.
    assign rnd = {y_reg[39], y_reg} + (y_reg[39] ? 41'h0_0000_FFFF : 41'd0);
    assign q   = rnd[40:16];
    always_comb
    begin
        if ((q[24:15] == 10'h000) || (q[24:15] == 10'h3FF))
        begin
            r = q[15:0];
        end
        else
        begin
            r = q[24] ? S_MIN : S_MAX;
        end
    end

    // Noise gate: magnitudes strictly below the threshold become zero.
    assign r17   = {r[15], r};
    assign thr17 = {2'b00, gate_thr_reg};
    assign g     = ((r17 < thr17) && (r17 > -thr17)) ? 16'sd0 : r;

    // Section history, cleared by reset and updated when a section sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (cmd.acc)
        begin
            x2_reg[cmd.job] <= x1;
            x1_reg[cmd.job] <= x0;
            y2_reg[cmd.job] <= y1;
            y1_reg[cmd.job] <= y_sat;
        end
    end

    // Pipeline of the shared section datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_left_reg  <= s_tdata[15:0];
            in_right_reg <= s_tdata[31:16];
        end
        if (cmd.mul)
        begin
            ff_reg  <= ff_mul;
            ph1_reg <= ph1_mul;
            pl1_reg <= pl1_mul;
            ph2_reg <= ph2_mul;
            pl2_reg <= pl2_mul;
        end
        if (cmd.part)
        begin
            ffq_reg <= ff_reg[50:14];
            p1_reg  <= t1[56:14];
            p2_reg  <= t2[56:14];
        end
        if (cmd.acc)
        begin
            y_reg <= y_sat;
        end
        if (cmd.res)
        begin
            if (!sec)
            begin
                sec_result_reg <= r;
            end
            else if (!ch)
            begin
                res_left_reg <= g;
            end
            else
            begin
                res_right_reg <= g;
            end
        end
        if (cmd.load_out)
        begin
            m_data_reg <= {res_right_reg, res_left_reg};
        end
    end

    assign m_tdata = m_data_reg;

endmodule

@@ hdl/stereo_bandpass_biquad_gate_top.sv @@
// Stereo band-pass filter with noise gate. Each input word carries one stereo
// frame (left sample in bits 15:0, right in 31:16); each channel runs through
// a high-pass and then a low-pass biquad section with Q2.30 coefficients set
// on the write port, and filtered samples whose magnitude is below the gate
// threshold come out as zero, one output word per input word in the same
// layout. Each frame goes through these steps before the next can be
// accepted: the idle state takes the word; multiply, partial recombine,
// sum and saturate, and truncate (gated only for low-pass) run for each of
// the four sections, which share a single section datapath and run one after
// another; then the output register is loaded when free. A finished result
// waits in the output register while the next frame is accepted. Coefficients
// and the threshold should be written only while no frame is in flight.
module stereo_bandpass_biquad_gate_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: left_sample[15:0], right_sample[15:0]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: left_out[15:0], right_out[15:0]
    output logic [31:0] m_tdata
);
    import sbg_pkg::*;

    sbg_cmd_t cmd;

    // Sequencer for the four sections and the stream handshakes.
    sbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Shared section datapath with coefficients and history.
    sbg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbg_pkg::*;

    // Index 7 is not decoded by the block; writes there must change nothing.
    localparam logic [2:0] CFG_SPARE = 3'd7;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_WORDS = 200;

    localparam longint ACC_HI    = longint'($signed(Y_MAX));
    localparam longint ACC_LO    = longint'($signed(Y_MIN));
    localparam longint SAMPLE_HI = longint'($signed(S_MAX));
    localparam longint SAMPLE_LO = longint'($signed(S_MIN));

    // One stereo frame, left sample in the low half of the word.
    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } frame_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_FRAME
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  index;
        logic [31:0] data;
        frame_t      word;
        logic        fixed;
        frame_t      fixed_word;
    } row_t;

    typedef struct packed {
        logic   fixed;
        frame_t fixed_word;
    } word_note_t;

    typedef struct packed {
        frame_t filtered;
        logic   fixed;
        frame_t fixed_word;
    } filtered_t;

    typedef enum logic [1:0] {
        SET_RESET,
        SET_NEAR,
        SET_WILD,
        SET_EDGE
    } set_kind_e;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    bit idle_on = 1'b1;
    int errors = 0;
    int cycle_count = 0;

    // Filter state and register copies kept alongside the block.
    logic signed [15:0] tap_in [8];
    logic signed [39:0] tap_out [8];
    logic        [30:0] cur_hp_gain;
    logic signed [31:0] cur_hp_fb1;
    logic signed [31:0] cur_hp_fb2;
    logic        [30:0] cur_lp_gain;
    logic signed [31:0] cur_lp_fb1;
    logic signed [31:0] cur_lp_fb2;
    logic        [14:0] cur_gate_thr;

    filtered_t  filtered_words [$];
    word_note_t word_notes [$];

    stereo_bandpass_biquad_gate_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void filter_reset();
        for (int i = 0; i < 8; i++)
        begin
            tap_in[i]  = '0;
            tap_out[i] = '0;
        end
        cur_hp_gain  = HP_GAIN_RST;
        cur_hp_fb1   = HP_FB1_RST;
        cur_hp_fb2   = HP_FB2_RST;
        cur_lp_gain  = LP_GAIN_RST;
        cur_lp_fb1   = LP_FB1_RST;
        cur_lp_fb2   = LP_FB2_RST;
        cur_gate_thr = GATE_THR_RST;
    endfunction

    function automatic void apply_write(logic [2:0] idx, logic [31:0] data);
        case (idx)
            CFG_HP_GAIN:  cur_hp_gain  = data[30:0];
            CFG_HP_FB1:   cur_hp_fb1   = data;
            CFG_HP_FB2:   cur_hp_fb2   = data;
            CFG_LP_GAIN:  cur_lp_gain  = data[30:0];
            CFG_LP_FB1:   cur_lp_fb1   = data;
            CFG_LP_FB2:   cur_lp_fb2   = data;
            CFG_GATE_THR: cur_gate_thr = data[14:0];
            default: ;
        endcase
    endfunction

    // One biquad section: feed-forward in Q.30 floored to Q.16, each feedback
    // product floored to Q.16 on its own, sum saturated to 40 bits.
    function automatic logic signed [15:0] run_section(int idx, logic signed [15:0] x0,
                                                       logic [30:0] gain, bit low_pass,
                                                       logic signed [31:0] fb1,
                                                       logic signed [31:0] fb2);
        longint x1, x2, taps, g, acc, whole;
        logic signed [71:0] coef, hist, p1, p2;
        x1 = tap_in[idx];
        x2 = tap_in[idx + 1];
        taps = low_pass ? (x0 + 2 * x1 + x2) : (x0 - 2 * x1 + x2);
        g = gain;
        acc = (g * taps) >>> 14;
        coef = fb1;
        hist = tap_out[idx];
        p1 = (coef * hist) >>> 30;
        coef = fb2;
        hist = tap_out[idx + 1];
        p2 = (coef * hist) >>> 30;
        acc = acc - longint'(p1) - longint'(p2);
        if (acc > ACC_HI)
            acc = ACC_HI;
        if (acc < ACC_LO)
            acc = ACC_LO;
        tap_in[idx + 1]  = tap_in[idx];
        tap_in[idx]      = x0;
        tap_out[idx + 1] = tap_out[idx];
        tap_out[idx]     = acc[39:0];
        // Drop the fraction toward zero, then clamp to a 16-bit sample.
        whole = (acc >= 0) ? (acc >>> 16) : -((-acc) >>> 16);
        if (whole > SAMPLE_HI)
            whole = SAMPLE_HI;
        if (whole < SAMPLE_LO)
            whole = SAMPLE_LO;
        return whole[15:0];
    endfunction

    function automatic logic signed [15:0] filter_channel(int ch, logic signed [15:0] x);
        logic signed [15:0] s;
        int thr;
        s = run_section(ch * 4, x, cur_hp_gain, 1'b0, cur_hp_fb1, cur_hp_fb2);
        s = run_section(ch * 4 + 2, s, cur_lp_gain, 1'b1, cur_lp_fb1, cur_lp_fb2);
        thr = cur_gate_thr;
        if (int'(s) > -thr && int'(s) < thr)
            s = '0;
        return s;
    endfunction

    function automatic frame_t filter_frame(frame_t f);
        frame_t r;
        r.left  = filter_channel(0, f.left);
        r.right = filter_channel(1, f.right);
        return r;
    endfunction

    task automatic check_sample(string name, logic signed [15:0] want,
                                logic signed [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Watch both handshakes and the write port at every edge. Results are
    // taken before new words so that a word and a result on the same edge
    // are matched in order.
    always @(posedge clk)
    begin : watch
        filtered_t  oldest;
        word_note_t note;
        filtered_t  entry;
        frame_t     got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (filtered_words.size() == 0)
                begin
                    $display("%0t ns: output word expected none, got %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    oldest = filtered_words.pop_front();
                    check_sample("left_out", oldest.filtered.left, got.left);
                    check_sample("right_out", oldest.filtered.right, got.right);
                    if (oldest.fixed)
                    begin
                        check_sample("left_out (fixed)", oldest.fixed_word.left, got.left);
                        check_sample("right_out (fixed)", oldest.fixed_word.right,
                                     got.right);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                note = '0;
                if (word_notes.size() != 0)
                    note = word_notes.pop_front();
                entry.filtered   = filter_frame(frame_t'(s_tdata));
                entry.fixed      = note.fixed;
                entry.fixed_word = note.fixed_word;
                filtered_words.push_back(entry);
            end
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
        end
    end

    // Receiver: while idling is on, stalls come in bursts of random length.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[stereo_bandpass_biquad_gate_top] ERROR");
        $finish;
    end

    task automatic send_word(frame_t f, logic fixed, frame_t fixed_word);
        word_notes.push_back('{fixed, fixed_word});
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Let every word in flight come out before the registers are touched.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (filtered_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    function automatic row_t write_row(logic [2:0] idx, logic [31:0] data);
        row_t r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.index = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic row_t word_row(logic [15:0] l, logic [15:0] r_s);
        row_t r;
        r = '0;
        r.kind       = ROW_FRAME;
        r.word.left  = l;
        r.word.right = r_s;
        return r;
    endfunction

    function automatic row_t fixed_row(logic [15:0] l, logic [15:0] r_s,
                                       logic [15:0] want_l, logic [15:0] want_r);
        row_t r;
        r = word_row(l, r_s);
        r.fixed            = 1'b1;
        r.fixed_word.left  = want_l;
        r.fixed_word.right = want_r;
        return r;
    endfunction

    function automatic logic [31:0] jitter(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'($urandom_range(1, 64));
            2:       return 32'($urandom_range(0, 2000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_edge_coef();
        case ($urandom_range(0, 2))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Mostly full-range samples, with some quiet signal and the rails.
    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            7:       return 16'(int'($urandom_range(0, 512)) - 256);
            8:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            9:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic program_set(set_kind_e kind);
        logic [31:0] v [7];
        case (kind)
            SET_RESET:
            begin
                v[0] = 32'(HP_GAIN_RST);
                v[1] = HP_FB1_RST;
                v[2] = HP_FB2_RST;
                v[3] = 32'(LP_GAIN_RST);
                v[4] = LP_FB1_RST;
                v[5] = LP_FB2_RST;
                v[6] = 32'(GATE_THR_RST);
            end
            SET_NEAR:
            begin
                v[0] = 32'(HP_GAIN_RST) + jitter(1 << 19);
                v[1] = HP_FB1_RST + jitter(1 << 16);
                v[2] = HP_FB2_RST + jitter(1 << 16);
                v[3] = 32'($urandom_range(0, 1 << 28));
                v[4] = LP_FB1_RST + jitter(1 << 16);
                v[5] = LP_FB2_RST + jitter(1 << 16);
                v[6] = pick_threshold();
            end
            SET_WILD:
            begin
                for (int i = 0; i < 7; i++)
                    v[i] = $urandom;
            end
            default:
            begin
                v[0] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                v[1] = pick_edge_coef();
                v[2] = pick_edge_coef();
                v[3] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                v[4] = pick_edge_coef();
                v[5] = pick_edge_coef();
                v[6] = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
            end
        endcase
        reg_write(CFG_HP_GAIN, v[0]);
        reg_write(CFG_HP_FB1, v[1]);
        reg_write(CFG_HP_FB2, v[2]);
        reg_write(CFG_LP_GAIN, v[3]);
        reg_write(CFG_LP_FB1, v[4]);
        reg_write(CFG_LP_FB2, v[5]);
        reg_write(CFG_GATE_THR, v[6]);
        if ($urandom_range(0, 1))
            reg_write(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        row_t      rows [$];
        set_kind_e plan [7];
        frame_t    f;
        bit        cfg_busy;
        filter_reset();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_busy  = 1'b0;
        plan = '{SET_RESET, SET_NEAR, SET_WILD, SET_NEAR, SET_EDGE, SET_NEAR, SET_RESET};

        // Straight after reset silence stays silent; then the rails and
        // bit patterns through the default band-pass.
        rows.push_back(fixed_row(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(word_row(16'h7FFF, 16'h8000));
        rows.push_back(word_row(16'h8000, 16'h7FFF));
        rows.push_back(word_row(16'h7FFF, 16'h7FFF));
        rows.push_back(word_row(16'h8000, 16'h8000));
        rows.push_back(word_row(16'h0001, 16'hFFFF));
        rows.push_back(word_row(16'h5555, 16'hAAAA));
        rows.push_back(word_row(16'h0000, 16'h0000));
        // With a zero threshold nothing is gated.
        rows.push_back(write_row(CFG_GATE_THR, 32'd0));
        rows.push_back(word_row(16'h0003, 16'hFFFD));
        rows.push_back(word_row(16'hFFED, 16'h0013));
        rows.push_back(word_row(16'h0000, 16'h0000));
        // Largest coefficients drive both the stored output and the sample
        // into saturation; the top gain bit is not stored.
        rows.push_back(write_row(CFG_HP_GAIN, 32'hFFFF_FFFF));
        rows.push_back(write_row(CFG_HP_FB1, 32'h7FFF_FFFF));
        rows.push_back(write_row(CFG_HP_FB2, 32'h8000_0000));
        rows.push_back(write_row(CFG_LP_GAIN, 32'h7FFF_FFFF));
        rows.push_back(write_row(CFG_LP_FB1, 32'h8000_0000));
        rows.push_back(write_row(CFG_LP_FB2, 32'h7FFF_FFFF));
        rows.push_back(write_row(CFG_GATE_THR, 32'h0000_7FFF));
        rows.push_back(word_row(16'h7FFF, 16'h8000));
        rows.push_back(word_row(16'h7FFF, 16'h8000));
        rows.push_back(word_row(16'h8000, 16'h7FFF));
        rows.push_back(word_row(16'h0000, 16'h0000));
        // All coefficients zero: every section output is zero whatever the
        // history. Upper threshold bits and the spare index are ignored.
        rows.push_back(write_row(CFG_HP_GAIN, 32'd0));
        rows.push_back(write_row(CFG_HP_FB1, 32'd0));
        rows.push_back(write_row(CFG_HP_FB2, 32'd0));
        rows.push_back(write_row(CFG_LP_GAIN, 32'd0));
        rows.push_back(write_row(CFG_LP_FB1, 32'd0));
        rows.push_back(write_row(CFG_LP_FB2, 32'd0));
        rows.push_back(write_row(CFG_GATE_THR, 32'hFFFF_8014));
        rows.push_back(write_row(CFG_SPARE, 32'hDEAD_BEEF));
        rows.push_back(fixed_row(16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
        rows.push_back(fixed_row(16'h8000, 16'h7FFF, 16'h0000, 16'h0000));
        // Unity gains with no feedback and the highest threshold: the most
        // negative sample must still get through the gate.
        rows.push_back(write_row(CFG_HP_GAIN, 32'h4000_0000));
        rows.push_back(write_row(CFG_LP_GAIN, 32'h4000_0000));
        rows.push_back(write_row(CFG_GATE_THR, 32'h0000_7FFF));
        rows.push_back(word_row(16'h8000, 16'h7FFF));
        rows.push_back(word_row(16'h8000, 16'h8000));
        rows.push_back(word_row(16'h0064, 16'hFF9C));
        // Back to the power-up coefficients.
        rows.push_back(write_row(CFG_HP_GAIN, 32'(HP_GAIN_RST)));
        rows.push_back(write_row(CFG_HP_FB1, HP_FB1_RST));
        rows.push_back(write_row(CFG_HP_FB2, HP_FB2_RST));
        rows.push_back(write_row(CFG_LP_GAIN, 32'(LP_GAIN_RST)));
        rows.push_back(write_row(CFG_LP_FB1, LP_FB1_RST));
        rows.push_back(write_row(CFG_LP_FB2, LP_FB2_RST));
        rows.push_back(write_row(CFG_GATE_THR, 32'(GATE_THR_RST)));
        rows.push_back(word_row(16'h03E8, 16'hFC18));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words.
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                if (!cfg_busy)
                    wait_idle();
                reg_write(rows[i].index, rows[i].data);
                cfg_busy = 1'b1;
            end
            else
            begin
                if (cfg_busy)
                    cfg_we <= 1'b0;
                cfg_busy = 1'b0;
                send_word(rows[i].word, rows[i].fixed, rows[i].fixed_word);
            end
        end

        // Random words under several register settings; the last phase
        // runs with no idling on either side.
        foreach (plan[p])
        begin
            if (p == 6)
                idle_on = 1'b0;
            wait_idle();
            program_set(plan[p]);
            repeat (PHASE_WORDS)
            begin
                f.left  = random_sample();
                f.right = random_sample();
                send_word(f, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (24) @(posedge clk);
        if (errors == 0)
            $display("[stereo_bandpass_biquad_gate_top] OK");
        else
            $display("[stereo_bandpass_biquad_gate_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sbg_pkg.sv
hdl/sbg_ctrl.sv
hdl/sbg_datapath.sv
hdl/stereo_bandpass_biquad_gate_top.sv
tb/sv/tb.sv
